// File: rtl/core/scpwm_pkg.sv
// Shared types, codes and register map of the sixteen-channel PWM controller.
`default_nettype none

package scpwm_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_TICK  = 2'd2
	} kind_t;

	// Register map
	localparam logic [7:0] ADDR_MODE1    = 8'd0;
	localparam logic [7:0] ADDR_MODE2    = 8'd1;
	localparam int         ADDR_CH_BASE  = 6;
	localparam logic [7:0] ADDR_ALL_BASE = 8'd250;
	localparam logic [7:0] ADDR_ALL_LAST = 8'd253;
	localparam logic [7:0] ADDR_PRESCALE = 8'd254;

	// Byte positions inside one channel
	localparam int BYTE_ON_L  = 0;
	localparam int BYTE_ON_H  = 1;
	localparam int BYTE_OFF_L = 2;
	localparam int BYTE_OFF_H = 3;

	// Control bits
	localparam int         FULL_BIT_POS   = 4;
	localparam int         SLEEP_BIT_POS  = 4;
	localparam int         INVERT_BIT_POS = 4;
	localparam logic [7:0] MIN_PRESCALE   = 8'd3;

	// Reset values
	localparam logic [7:0] MODE1_RST    = 8'h11;
	localparam logic [7:0] MODE2_RST    = 8'h04;
	localparam logic [7:0] PRESCALE_RST = 8'd30;
	localparam logic [7:0] OFF_H_RST    = 8'h10;

	// Parameter defaults
	localparam int CHANNELS_DEF   = 16;
	localparam int COUNT_BITS_DEF = 12;
	localparam int MAX_CHANNELS   = 16;

	// Four register bytes of one channel: ON_L, ON_H, OFF_L, OFF_H
	typedef logic [3:0][7:0] chan_t;

endpackage

`default_nettype wire

// File: rtl/core/sixteen_channel_pwm_controller.sv
// Top level of the sixteen-channel 12-bit PWM controller: registers, counter and compares.
`default_nettype none

// Takes one transfer per clock: a register write, a register read or an oscillator
// tick, and returns one result transfer for each, in order. Sustained rate is one
// item per cycle unless m_tready stalls; an item passes the input register, then the
// result register, with all register updates and the channel compares between them.
// The result carries the byte read (zero for writes and ticks), the level of every
// output after the item and the MODE1 sleep bit. Channel registers sit in flip-flops
// so that every channel compares against the shared period counter in parallel.
module sixteen_channel_pwm_controller
	import scpwm_pkg::*;
#(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] reg_addr, [15:8] write_data
	input  wire logic [1:0]  s_tuser,   // [1:0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // [7:0] read_data, [23:8] pwm_out, [24] sleeping
);

	localparam int CH_END = ADDR_CH_BASE + 4 * CHANNELS;

	// Input stage
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  addr_s1;
	logic [7:0]  data_s1;

	// Architectural state
	logic [7:0]            mode_one_q;
	logic [7:0]            mode_two_q;
	logic [7:0]            prescale_q;
	logic [7:0]            divider_q;
	logic [COUNT_BITS-1:0] period_q;
	chan_t                 chan_q [CHANNELS];

	// Next state
	logic [7:0]            mode_one_d;
	logic [7:0]            mode_two_d;
	logic [7:0]            prescale_d;
	logic [7:0]            divider_d;
	logic [COUNT_BITS-1:0] period_d;
	chan_t                 chan_d [CHANNELS];

	// Decode and result
	logic       advance;
	logic       is_write;
	logic       is_read;
	logic       is_tick;
	logic       asleep;
	logic       ch_hit;
	logic [7:0] ch_off;
	logic [3:0] ch_sel;
	logic [1:0] byte_sel;
	logic [7:0] all_off;
	logic       all_hit;
	logic [7:0] rd_d;
	logic [15:0] pwm_d;

	// Result register
	logic       out_valid_q;
	logic [31:0] out_data_q;

	// Handshake: the stage moves when the result slot is free or being taken
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Capture the incoming transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			addr_s1 <= s_tdata[7:0];
			data_s1 <= s_tdata[15:8];
		end
	end

	// Decode the item held in the input stage
	always_comb begin
		is_write = valid_s1 && (kind_s1 == KIND_WRITE);
		is_read  = valid_s1 && (kind_s1 == KIND_READ);
		is_tick  = valid_s1 && (kind_s1 == KIND_TICK);
		asleep   = mode_one_q[SLEEP_BIT_POS];
		ch_off   = addr_s1 - 8'(ADDR_CH_BASE);
		ch_hit   = (addr_s1 >= 8'(ADDR_CH_BASE)) && (addr_s1 < 8'(CH_END));
		ch_sel   = ch_off[5:2];
		byte_sel = ch_off[1:0];
		all_off  = addr_s1 - ADDR_ALL_BASE;
		all_hit  = (addr_s1 >= ADDR_ALL_BASE) && (addr_s1 <= ADDR_ALL_LAST);
	end

	// Work out the state after the item
	always_comb begin
		mode_one_d = mode_one_q;
		mode_two_d = mode_two_q;
		prescale_d = prescale_q;
		divider_d  = divider_q;
		period_d   = period_q;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			chan_d[ch] = chan_q[ch];
		end

		if (is_write) begin
			if (addr_s1 == ADDR_MODE1) begin
				mode_one_d = data_s1;
			end else if (addr_s1 == ADDR_MODE2) begin
				mode_two_d = data_s1;
			end else if (ch_hit) begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					if (ch_sel == 4'(ch)) begin
						chan_d[ch][byte_sel] = data_s1;
					end
				end
			end else if (all_hit) begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					chan_d[ch][all_off[1:0]] = data_s1;
				end
			end else if (addr_s1 == ADDR_PRESCALE) begin
				if (asleep) begin
					prescale_d = (data_s1 < MIN_PRESCALE) ? MIN_PRESCALE : data_s1;
				end
			end
		end

		// Advance the divider and period counter while the oscillator runs
		if (is_tick && !asleep) begin
			if (divider_q >= prescale_q) begin
				divider_d = '0;
				period_d  = period_q + 1'b1;
			end else begin
				divider_d = divider_q + 8'd1;
			end
		end
	end

	// Read back the addressed byte
	always_comb begin
		rd_d = '0;
		if (is_read) begin
			if (addr_s1 == ADDR_MODE1) begin
				rd_d = mode_one_q;
			end else if (addr_s1 == ADDR_MODE2) begin
				rd_d = mode_two_q;
			end else if (ch_hit) begin
				for (int ch = 0; ch < CHANNELS; ch++) begin
					if (ch_sel == 4'(ch)) begin
						rd_d = chan_q[ch][byte_sel];
					end
				end
			end else if (addr_s1 == ADDR_PRESCALE) begin
				rd_d = prescale_q;
			end
		end
	end

	// Compare every channel against the updated counter; full-off wins over full-on
	always_comb begin
		logic [11:0]           on_full;
		logic [11:0]           off_full;
		logic [COUNT_BITS-1:0] on_val;
		logic [COUNT_BITS-1:0] off_val;
		logic                  lv;
		pwm_d = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			on_full  = {chan_d[ch][BYTE_ON_H][3:0], chan_d[ch][BYTE_ON_L]};
			off_full = {chan_d[ch][BYTE_OFF_H][3:0], chan_d[ch][BYTE_OFF_L]};
			on_val   = on_full[COUNT_BITS-1:0];
			off_val  = off_full[COUNT_BITS-1:0];
			if (chan_d[ch][BYTE_OFF_H][FULL_BIT_POS]) begin
				lv = 1'b0;
			end else if (chan_d[ch][BYTE_ON_H][FULL_BIT_POS]) begin
				lv = 1'b1;
			end else if (on_val == off_val) begin
				lv = 1'b0;
			end else if (on_val < off_val) begin
				lv = (period_d >= on_val) && (period_d < off_val);
			end else begin
				lv = (period_d >= on_val) || (period_d < off_val);
			end
			pwm_d[ch] = lv ^ mode_two_d[INVERT_BIT_POS];
		end
	end

	// Commit state and result together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_one_q  <= MODE1_RST;
			mode_two_q  <= MODE2_RST;
			prescale_q  <= PRESCALE_RST;
			divider_q   <= '0;
			period_q    <= '0;
			out_valid_q <= 1'b0;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				chan_q[ch] <= {OFF_H_RST, 8'h00, 8'h00, 8'h00};
			end
		end else if (advance) begin
			mode_one_q  <= mode_one_d;
			mode_two_q  <= mode_two_d;
			prescale_q  <= prescale_d;
			divider_q   <= divider_d;
			period_q    <= period_d;
			out_valid_q <= valid_s1;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				chan_q[ch] <= chan_d[ch];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= {7'd0, mode_one_d[SLEEP_BIT_POS], pwm_d, rd_d};
		end
	end

	// Checks
	a_sleep_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[24] == mode_one_q[SLEEP_BIT_POS]))
		else $error("result sleep flag differs from MODE1");

	a_prescale_floor: assert property (@(posedge clk) disable iff (!arst_n)
		prescale_q >= MIN_PRESCALE)
		else $error("prescale below minimum");

	a_period_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && is_tick && !asleep) |=> $stable(period_q))
		else $error("period counter moved without a running tick");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty result slot");

endmodule

`default_nettype wire
